// ----- src/padded_frame_walsh_hadamard_unit_assert.svh -----
// Assertion macros shared by the checker of the transform unit.
`ifndef PADDED_FRAME_WALSH_HADAMARD_UNIT_ASSERT_SVH
`define PADDED_FRAME_WALSH_HADAMARD_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFWH_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFWH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pfwh_pkg.sv -----
`default_nettype none
package pfwh_pkg;

  localparam int SIDE_DEF = 64;

  localparam int PIX_W   = 8;
  localparam int IDX_W   = 13;
  localparam int COEF_W  = 21;
  localparam int DIM_W   = 7;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic               func;
    logic [PIX_W-1:0]   pixel;
    logic [IDX_W-1:0]   coef_index;
  } pfwh_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [1:0]               status;
  } pfwh_out_t;

  // Commands from the controller to the datapath for the current cycle.
  typedef struct packed {
    logic       wr_zero;
    logic       wr_pix;
    logic       bfly;
    logic       upper;
    logic       fetch;
    logic       src_sel;
    logic [1:0] status;
  } pfwh_cmd_t;

endpackage
`default_nettype wire

// ----- src/padded_frame_walsh_hadamard_unit.sv -----
// Load: most pixels leave busy low, but the first pixel of a frame keeps busy high
// while buffer A is swept to zero. The last pixel keeps busy high while the
// butterfly stages run, one butterfly output a cycle through the two buffer
// memories. Fetch: one per cycle while busy is low, result strobed the cycle after
// start; the receiver cannot stall. Synchronous reset clears control state and the
// registers to 64; memories are not reset.
`default_nettype none
module padded_frame_walsh_hadamard_unit #(
  parameter int SIDE = pfwh_pkg::SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  pfwh_pkg::pfwh_in_t         in_data,
  output logic                       out_valid,
  output pfwh_pkg::pfwh_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [pfwh_pkg::DIM_W-1:0] cfg_data
);

  localparam int AW = 2 * $clog2(SIDE);

  pfwh_pkg::pfwh_cmd_t        cmd;
  logic [AW-1:0]              addr0;
  logic [AW-1:0]              addr1;
  logic [pfwh_pkg::PIX_W-1:0] wr_pixel;

  pfwh_ctrl #(
    .SIDE(SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .addr0     (addr0),
    .addr1     (addr1),
    .wr_pixel  (wr_pixel)
  );

  pfwh_datapath #(
    .SIDE(SIDE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr0     (addr0),
    .addr1     (addr1),
    .wr_pixel  (wr_pixel),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- src/pfwh_ctrl.sv -----
`default_nettype none
module pfwh_ctrl #(
  parameter int SIDE = pfwh_pkg::SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pfwh_pkg::pfwh_in_t            in_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [pfwh_pkg::DIM_W-1:0]    cfg_data,
  output pfwh_pkg::pfwh_cmd_t           cmd,
  output logic [2*$clog2(SIDE)-1:0]     addr0,
  output logic [2*$clog2(SIDE)-1:0]     addr1,
  output logic [pfwh_pkg::PIX_W-1:0]    wr_pixel
);

  localparam int CW   = $clog2(SIDE);
  localparam int AW   = 2 * CW;
  localparam int SW   = $clog2(AW);
  localparam int AREA = SIDE * SIDE;
  localparam int DW   = pfwh_pkg::DIM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_XFORM = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [DW-1:0]              width_r, width_nxt;
  logic [DW-1:0]              height_r, height_nxt;
  logic [DW-1:0]              col_r, col_nxt;
  logic [DW-1:0]              row_r, row_nxt;
  logic                       done_r, done_nxt;
  logic                       src_sel_r, src_sel_nxt;
  logic [AW-1:0]              cnt_r, cnt_nxt;
  logic [SW-1:0]              stage_r, stage_nxt;
  logic [pfwh_pkg::PIX_W-1:0] pix_r, pix_nxt;

  logic          frame_ok;
  logic          accept;
  logic          first_px;
  logic          last_px;
  logic          col_end;
  logic [CW-1:0] xoff;
  logic [CW-1:0] yoff;
  logic [AW-1:0] pos;
  logic [AW-1:0] half;
  logic [31:0]   idx32;

  assign frame_ok = (width_r != '0) && (height_r != '0) && !width_r[0] && !height_r[0]
                    && ({{(32-DW){1'b0}}, width_r} <= 32'(SIDE))
                    && ({{(32-DW){1'b0}}, height_r} <= 32'(SIDE));
  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign first_px = (col_r == '0) && (row_r == '0);
  assign col_end  = (col_r == width_r - DW'(1));
  assign last_px  = col_end && (row_r == height_r - DW'(1));
  assign xoff     = CW'((32'(SIDE) - {{(32-DW){1'b0}}, width_r}) >> 1);
  assign yoff     = CW'((32'(SIDE) - {{(32-DW){1'b0}}, height_r}) >> 1);
  // The frame is stored transposed: the column selects the row of the store.
  assign pos      = {CW'(xoff + CW'(col_r)), CW'(yoff + CW'(row_r))};
  assign half     = {{(AW-1){1'b0}}, 1'b1} << stage_r;
  assign idx32    = {{(32-pfwh_pkg::IDX_W){1'b0}}, in_data.coef_index};

  always_comb begin
    state_nxt   = state_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    done_nxt    = done_r;
    src_sel_nxt = src_sel_r;
    cnt_nxt     = cnt_r;
    stage_nxt   = stage_r;
    pix_nxt     = pix_r;
    cmd         = '0;
    addr0       = cnt_r;
    addr1       = cnt_r ^ half;
    wr_pixel    = pix_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.func == pfwh_pkg::FUNC_FETCH) begin
            cmd.fetch   = 1'b1;
            cmd.src_sel = src_sel_r;
            addr0       = AW'(idx32 - 32'd1);
            if (!frame_ok) begin
              cmd.status = pfwh_pkg::ST_BAD_SIZE;
            end else if (!done_r) begin
              cmd.status = pfwh_pkg::ST_NOT_READY;
            end else if ((idx32 == 32'd0) || (idx32 > 32'(AREA))) begin
              cmd.status = pfwh_pkg::ST_RANGE;
            end else begin
              cmd.status = pfwh_pkg::ST_OK;
            end
          end else if (frame_ok) begin
            if (first_px) begin
              // A new frame: sweep buffer A to zero before the first pixel goes in.
              pix_nxt     = in_data.pixel;
              done_nxt    = 1'b0;
              src_sel_nxt = 1'b0;
              cnt_nxt     = '0;
              state_nxt   = S_CLEAR;
            end else begin
              cmd.wr_pix = 1'b1;
              addr0      = pos;
              wr_pixel   = in_data.pixel;
              if (last_px) begin
                col_nxt   = '0;
                row_nxt   = '0;
                cnt_nxt   = '0;
                stage_nxt = '0;
                state_nxt = S_XFORM;
              end else if (col_end) begin
                col_nxt = '0;
                row_nxt = row_r + DW'(1);
              end else begin
                col_nxt = col_r + DW'(1);
              end
            end
          end
        end
      end
      S_CLEAR: begin
        cmd.wr_zero = 1'b1;
        addr0       = cnt_r;
        cnt_nxt     = cnt_r + AW'(1);
        if (&cnt_r) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.wr_pix = 1'b1;
        addr0      = pos;
        wr_pixel   = pix_r;
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_r + DW'(1);
        end else begin
          col_nxt = col_r + DW'(1);
        end
        state_nxt = S_IDLE;
      end
      S_XFORM: begin
        cmd.bfly    = 1'b1;
        cmd.upper   = |(cnt_r & half);
        cmd.src_sel = src_sel_r;
        cnt_nxt     = cnt_r + AW'(1);
        if (&cnt_r) begin
          src_sel_nxt = !src_sel_r;
          if (stage_r == SW'(AW - 1)) begin
            state_nxt = S_DRAIN;
          end else begin
            stage_nxt = stage_r + SW'(1);
          end
        end
      end
      S_DRAIN: begin
        // The last butterfly result is written in this cycle.
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write abandons the frame in progress.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfwh_pkg::REG_WIDTH:  width_nxt  = cfg_data;
        pfwh_pkg::REG_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
      col_nxt  = '0;
      row_nxt  = '0;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      width_r   <= DW'(64);
      height_r  <= DW'(64);
      col_r     <= '0;
      row_r     <= '0;
      done_r    <= 1'b0;
      src_sel_r <= 1'b0;
      cnt_r     <= '0;
      stage_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      done_r    <= done_nxt;
      src_sel_r <= src_sel_nxt;
      cnt_r     <= cnt_nxt;
      stage_r   <= stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

endmodule
`default_nettype wire

// ----- src/pfwh_datapath.sv -----
`default_nettype none
module pfwh_datapath #(
  parameter int SIDE = pfwh_pkg::SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfwh_pkg::pfwh_cmd_t           cmd,
  input  logic [2*$clog2(SIDE)-1:0]     addr0,
  input  logic [2*$clog2(SIDE)-1:0]     addr1,
  input  logic [pfwh_pkg::PIX_W-1:0]    wr_pixel,
  output logic                          out_valid,
  output pfwh_pkg::pfwh_out_t           out_data
);

  localparam int AW   = 2 * $clog2(SIDE);
  localparam int AREA = SIDE * SIDE;
  localparam int VW   = pfwh_pkg::COEF_W;

  logic [VW-1:0] mem_a [AREA];
  logic [VW-1:0] mem_b [AREA];

  logic [VW-1:0] rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;

  logic          bfly_q_r;
  logic          upper_q_r;
  logic          src_q_r;
  logic [AW-1:0] waddr_q_r;
  logic          fetch_q_r;
  logic          fsel_q_r;
  logic [1:0]    status_q_r;

  logic [VW-1:0] p_val, q_val, bf_val;
  logic          we_a, we_b;
  logic [AW-1:0] wa_addr;
  logic [VW-1:0] wa_data;

  // p is the entry at the butterfly's own index, q the one at its partner.
  assign p_val  = src_q_r ? rd_b0_r : rd_a0_r;
  assign q_val  = src_q_r ? rd_b1_r : rd_a1_r;
  assign bf_val = upper_q_r ? (q_val - p_val) : (p_val + q_val);

  assign we_a    = cmd.wr_zero || cmd.wr_pix || (bfly_q_r && src_q_r);
  assign we_b    = bfly_q_r && !src_q_r;
  assign wa_addr = bfly_q_r ? waddr_q_r : addr0;
  assign wa_data = bfly_q_r ? bf_val :
                   (cmd.wr_pix ? {{(VW-pfwh_pkg::PIX_W){1'b0}}, wr_pixel} : '0);

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_addr] <= wa_data;
    end
    rd_a0_r <= mem_a[addr0];
    rd_a1_r <= mem_a[addr1];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr_q_r] <= bf_val;
    end
    rd_b0_r <= mem_b[addr0];
    rd_b1_r <= mem_b[addr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bfly_q_r  <= 1'b0;
      fetch_q_r <= 1'b0;
    end else begin
      bfly_q_r  <= cmd.bfly;
      fetch_q_r <= cmd.fetch;
    end
  end

  always_ff @(posedge clk) begin
    upper_q_r  <= cmd.upper;
    src_q_r    <= cmd.src_sel;
    waddr_q_r  <= addr0;
    fsel_q_r   <= cmd.src_sel;
    status_q_r <= cmd.status;
  end

  assign out_valid            = fetch_q_r;
  assign out_data.status      = status_q_r;
  assign out_data.coefficient = (status_q_r == pfwh_pkg::ST_OK) ?
                                (fsel_q_r ? rd_b0_r : rd_a0_r) : '0;

endmodule
`default_nettype wire

// ----- src/pfwh_checker.sv -----
`default_nettype none
`include "padded_frame_walsh_hadamard_unit_assert.svh"
module pfwh_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input pfwh_pkg::pfwh_in_t  in_data,
  input logic                out_valid,
  input pfwh_pkg::pfwh_out_t out_data
);

  logic fetch_acc;
  logic load_acc;

  assign fetch_acc = start && !busy && (in_data.func == pfwh_pkg::FUNC_FETCH);
  assign load_acc  = start && !busy && (in_data.func == pfwh_pkg::FUNC_LOAD);

  // Every fetch item gives exactly one result in the next cycle.
  `PFWH_ASSERT_NEXT(a_fetch_gives_result, clk, rst_n, fetch_acc, out_valid, "fetch item gave no result")
  `PFWH_ASSERT_SAME(a_result_from_fetch, clk, rst_n, out_valid, $past(fetch_acc), "result without a fetch item")
  `PFWH_ASSERT_NEXT(a_load_silent, clk, rst_n, load_acc, !out_valid, "load item gave a result")
  // An error result always carries a zero coefficient.
  `PFWH_ASSERT_SAME(a_error_zero, clk, rst_n, out_valid && (out_data.status != pfwh_pkg::ST_OK), out_data.coefficient == '0, "error result with non-zero coefficient")

endmodule

bind padded_frame_walsh_hadamard_unit pfwh_checker u_pfwh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// ----- tb/tb_padded_frame_walsh_hadamard_unit.sv -----
module tb_padded_frame_walsh_hadamard_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfwh_pkg::*;

  localparam int SIDE = SIDE_DEF;
  localparam int AREA = SIDE * SIDE;
  localparam int IDX_MAX = (1 << IDX_W) - 1;
  // Busy time after the first pixel (store sweep) and after the last one (all stages).
  localparam int SWEEP_CYCLES = AREA + 100;
  localparam int STAGE_CYCLES = 2 * $clog2(SIDE) * AREA + 200;
  localparam int ITEM_GOAL = 1200;
  localparam int CALM_TAIL = 150;

  typedef enum logic [1:0] {STEP_ITEM, STEP_HOLD, STEP_REG} step_kind_e;

  typedef struct {
    step_kind_e         kind;
    pfwh_in_t           item;
    logic               reg_sel;
    logic [DIM_W-1:0]   reg_val;
  } step_t;

  typedef struct {
    pfwh_out_t          want;
    logic [IDX_W-1:0]   idx;
  } coef_expect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pfwh_in_t in_data = '0;
  logic out_valid;
  pfwh_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  padded_frame_walsh_hadamard_unit #(.SIDE(SIDE)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  step_t        step_q[$];
  coef_expect_t coef_expect_q[$];

  // Shadow of the block: the padded plane, transformed in place once a frame is complete.
  bit [31:0]        plane [AREA];
  int unsigned      pix_count;
  bit               coefs_ready;
  logic [DIM_W-1:0] frame_cols = 7'd64;
  logic [DIM_W-1:0] frame_rows = 7'd64;

  // Stimulus planning state.
  logic [DIM_W-1:0] plan_cols = 7'd64;
  logic [DIM_W-1:0] plan_rows = 7'd64;
  int items_planned = 0;
  int items_counted = 0;

  int gap_left = 0;
  int settle_left = 0;
  int items_taken = 0;
  int loads_taken = 0;
  int fetches_taken = 0;
  int regs_taken = 0;
  int frames_done = 0;
  int results_seen = 0;
  int errors = 0;
  int status_seen [4] = '{default: 0};

  function automatic bit dims_ok(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
    return cols != 0 && rows != 0 && !cols[0] && !rows[0] && cols <= SIDE && rows <= SIDE;
  endfunction

  // In-place butterflies give the same words as the ping-pong passes of the block.
  function automatic void transform_plane();
    bit [31:0] p, q;
    for (int half = 1; half < AREA; half <<= 1)
      for (int base = 0; base < AREA; base += 2 * half)
        for (int k = 0; k < half; k++) begin
          p = plane[base + k];
          q = plane[base + half + k];
          plane[base + k] = p + q;
          plane[base + half + k] = p - q;
        end
  endfunction

  function automatic void accept_item(input pfwh_in_t it);
    int r, c, pos;
    coef_expect_t e;
    items_taken++;
    if (it.func == FUNC_LOAD) begin
      loads_taken++;
      if (settle_left < 4) settle_left = 4;
      if (!dims_ok(frame_cols, frame_rows)) return;
      if (pix_count == 0) begin
        foreach (plane[i]) plane[i] = '0;
        coefs_ready = 1'b0;
        settle_left = SWEEP_CYCLES;
      end
      r = pix_count / frame_cols;
      c = pix_count % frame_cols;
      pos = ((SIDE - frame_cols) / 2 + c) * SIDE + (SIDE - frame_rows) / 2 + r;
      plane[pos] = 32'(it.pixel);
      pix_count++;
      if (pix_count >= frame_cols * frame_rows) begin
        pix_count = 0;
        transform_plane();
        coefs_ready = 1'b1;
        frames_done++;
        settle_left = STAGE_CYCLES;
      end
    end else begin
      fetches_taken++;
      if (settle_left < 4) settle_left = 4;
      e.idx = it.coef_index;
      e.want.coefficient = '0;
      if (!dims_ok(frame_cols, frame_rows))
        e.want.status = ST_BAD_SIZE;
      else if (!coefs_ready)
        e.want.status = ST_NOT_READY;
      else if (it.coef_index == 0 || it.coef_index > AREA)
        e.want.status = ST_RANGE;
      else begin
        e.want.status = ST_OK;
        e.want.coefficient = plane[it.coef_index - 1][COEF_W-1:0];
      end
      coef_expect_q.push_back(e);
    end
  endfunction

  function automatic void push_load(input logic [PIX_W-1:0] pix);
    step_t s;
    s.kind = STEP_ITEM;
    s.item.func = FUNC_LOAD;
    s.item.pixel = pix;
    s.item.coef_index = IDX_W'($urandom_range(0, IDX_MAX));
    s.reg_sel = REG_WIDTH;
    s.reg_val = '0;
    step_q.push_back(s);
    items_planned++;
    if (dims_ok(plan_cols, plan_rows)) items_counted++;
  endfunction

  function automatic void push_fetch(input int idx);
    step_t s;
    s.kind = STEP_ITEM;
    s.item.func = FUNC_FETCH;
    s.item.pixel = PIX_W'($urandom_range(0, 255));
    s.item.coef_index = IDX_W'(idx);
    s.reg_sel = REG_WIDTH;
    s.reg_val = '0;
    step_q.push_back(s);
    items_planned++;
    items_counted++;
  endfunction

  function automatic void push_reg(input logic sel, input int val);
    step_t s;
    s.kind = STEP_REG;
    s.item = '0;
    s.reg_sel = sel;
    s.reg_val = DIM_W'(val);
    step_q.push_back(s);
    if (sel == REG_WIDTH) plan_cols = DIM_W'(val);
    else plan_rows = DIM_W'(val);
  endfunction

  function automatic void push_hold();
    step_t s;
    s.kind = STEP_HOLD;
    s.item = '0;
    s.reg_sel = REG_WIDTH;
    s.reg_val = '0;
    step_q.push_back(s);
  endfunction

  function automatic int pick_index();
    if ($urandom_range(0, 9) == 0)
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(AREA + 1, IDX_MAX);
    return $urandom_range(1, AREA);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Loads a whole frame of the planned size; stray fetches mid-frame must read not ready.
  function automatic void push_frame();
    for (int n = 0; n < plan_cols * plan_rows; n++) begin
      push_load(pick_pixel());
      if ($urandom_range(0, 24) == 0) push_fetch(pick_index());
    end
  endfunction

  always @(posedge clk) begin
    logic go_item, go_reg;
    go_item = start;
    go_reg = cfg_valid;
    if (!rst_n) begin
      go_item = 1'b0;
      go_reg = 1'b0;
      gap_left = 0;
      settle_left = 0;
    end else begin
      if (settle_left > 0) settle_left--;
      if (start && !busy) begin
        accept_item(in_data);
        go_item = 1'b0;
        if (items_taken + CALM_TAIL < items_planned && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 16);
      end
      if (cfg_valid && cfg_ready) begin
        regs_taken++;
        if (cfg_index == REG_WIDTH) frame_cols = cfg_data;
        else frame_rows = cfg_data;
        pix_count = 0;
        coefs_ready = 1'b0;
        go_reg = 1'b0;
        if (settle_left < 4) settle_left = 4;
        if (items_taken + CALM_TAIL < items_planned && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 16);
      end
      if (!go_item && !go_reg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (step_q.size() != 0) begin
          case (step_q[0].kind)
            STEP_ITEM: begin
              in_data <= step_q[0].item;
              go_item = 1'b1;
              step_q.delete(0);
            end
            STEP_HOLD: begin
              if (coef_expect_q.size() == 0) step_q.delete(0);
            end
            STEP_REG: begin
              // Registers change only once the block has drained.
              if (coef_expect_q.size() == 0 && settle_left == 0) begin
                cfg_index <= step_q[0].reg_sel;
                cfg_data <= step_q[0].reg_val;
                go_reg = 1'b1;
                step_q.delete(0);
              end
            end
            default: step_q.delete(0);
          endcase
        end
      end
    end
    start <= go_item;
    cfg_valid <= go_reg;
  end

  always @(posedge clk) begin
    coef_expect_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      status_seen[out_data.status]++;
      if (coef_expect_q.size() == 0) begin
        $display("%0t: result with nothing expected: coefficient %0d status %0d",
                 $time, out_data.coefficient, out_data.status);
        errors++;
      end else begin
        e = coef_expect_q.pop_front();
        if (out_data.status !== e.want.status) begin
          $display("%0t: status for index %0d expected %0d got %0d",
                   $time, e.idx, e.want.status, out_data.status);
          errors++;
        end
        if (out_data.coefficient !== e.want.coefficient) begin
          $display("%0t: coefficient for index %0d expected %0d got %0d",
                   $time, e.idx, e.want.coefficient, out_data.coefficient);
          errors++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int kind, cols, rows, half_max, n_fetch, cut, good_frames, rounds;
    bit last_good;

    // Directed part: not ready after reset, each kind of bad size, then 2x2 frames.
    push_fetch(1);
    push_reg(REG_WIDTH, 3);
    push_fetch(AREA);
    push_load('0);
    push_reg(REG_WIDTH, 0);
    push_fetch(0);
    push_reg(REG_WIDTH, 127);
    push_fetch(IDX_MAX);
    push_reg(REG_WIDTH, 2);
    push_reg(REG_HEIGHT, 0);
    push_fetch(1);
    push_reg(REG_HEIGHT, 66);
    push_fetch(2);
    push_reg(REG_HEIGHT, 2);
    push_load('1);
    push_load('0);
    push_fetch(1);
    // A register write in mid-frame throws the partial frame away.
    push_reg(REG_WIDTH, 2);
    push_load('1);
    push_load('1);
    push_load('1);
    push_load('1);
    push_fetch(1);
    push_fetch(AREA);
    push_fetch(0);
    push_fetch(AREA + 1);
    push_fetch(IDX_MAX);
    push_fetch(SIDE + 1);
    // A load after a finished transform opens a new frame.
    push_load(8'd128);
    push_fetch(1);
    push_load(8'd1);
    push_load(8'd2);
    push_load(8'd3);
    push_fetch(1);
    push_fetch(2);

    good_frames = 0;
    rounds = 0;
    last_good = 1'b1;
    while (items_counted < ITEM_GOAL && good_frames < 12) begin
      kind = $urandom_range(0, 5);
      if (rounds < 2) kind = 2;
      if (kind == 0) begin
        case ($urandom_range(0, 2))
          0: cols = 0;
          1: cols = 2 * $urandom_range(0, 63) + 1;
          default: cols = $urandom_range(SIDE + 1, 127);
        endcase
        push_reg($urandom_range(0, 1) ? REG_WIDTH : REG_HEIGHT, cols);
        for (int n = $urandom_range(0, 4); n > 0; n--) push_load(pick_pixel());
        for (int n = $urandom_range(8, 20); n > 0; n--) push_fetch(pick_index());
        last_good = 1'b0;
      end else begin
        if (!(kind == 1 && last_good)) begin
          if (rounds == 0) begin
            cols = SIDE;
            rows = 2;
          end else if (rounds == 1) begin
            cols = 2;
            rows = SIDE;
          end else begin
            cols = 2 * $urandom_range(1, SIDE / 2);
            half_max = (160 / cols) / 2;
            if (half_max < 1) half_max = 1;
            if (half_max > SIDE / 2) half_max = SIDE / 2;
            rows = 2 * $urandom_range(1, half_max);
            if ($urandom_range(0, 1)) begin
              half_max = cols;
              cols = rows;
              rows = half_max;
            end
          end
          if (!dims_ok(plan_cols, plan_rows) || cols != plan_cols || $urandom_range(0, 1))
            push_reg(REG_WIDTH, cols);
          if (rows != plan_rows || !dims_ok(plan_cols, plan_rows))
            push_reg(REG_HEIGHT, rows);
        end
        if ($urandom_range(0, 2) == 0)
          for (int n = $urandom_range(1, 3); n > 0; n--) push_fetch(pick_index());
        if ($urandom_range(0, 7) == 0 && plan_cols * plan_rows > 2) begin
          cut = $urandom_range(1, plan_cols * plan_rows - 1);
          for (int n = 0; n < cut; n++) push_load(pick_pixel());
          push_reg(REG_WIDTH, plan_cols);
        end
        push_frame();
        if (rounds == 0 || $urandom_range(0, 3) == 0) push_hold();
        n_fetch = $urandom_range(50, 110);
        for (int n = 0; n < n_fetch; n++) push_fetch(pick_index());
        good_frames++;
        last_good = 1'b1;
      end
      rounds++;
    end
    // Fill up to the goal with fetches from the last frame.
    while (items_counted < ITEM_GOAL) push_fetch(pick_index());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (step_q.size() != 0 || start || cfg_valid) @(posedge clk);
    while (coef_expect_q.size() != 0) @(posedge clk);
    while (settle_left > 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Drove %0d items (%0d pixel loads, %0d fetches), %0d register writes, %0d transforms.",
             items_taken, loads_taken, fetches_taken, regs_taken, frames_done);
    $display("Results by status: ok %0d, not ready %0d, out of range %0d, bad size %0d.",
             status_seen[ST_OK], status_seen[ST_NOT_READY], status_seen[ST_RANGE],
             status_seen[ST_BAD_SIZE]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/pfwh_pkg.sv
src/pfwh_ctrl.sv
src/pfwh_datapath.sv
src/padded_frame_walsh_hadamard_unit.sv
src/pfwh_checker.sv
tb/tb_padded_frame_walsh_hadamard_unit.sv
